FILE: rtl/core/svna_pkg.sv
// ----------------------------------------------------------------------------
// svna_pkg
// Shared types and constants of the smooth vertex normal accumulator.
// ----------------------------------------------------------------------------
package svna_pkg;

  // Parameter defaults
  localparam int DEF_VERTEX_COUNT  = 1024;
  localparam int DEF_POSITION_BITS = 16;
  localparam int DEF_SUM_BITS      = 32;

  // Field and bus widths
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 17;
  localparam int POS_IN_W   = 16;
  localparam int NORM_W     = 16;
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 1;

  // Datapath widths
  localparam int EDGE_W     = 31;
  localparam int VEC_W      = 62;
  localparam int QUO_W      = 15;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_TRI   = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_CLEAR = 3'd0,
    KIND_LOAD  = 3'd1,
    KIND_TRI   = 3'd2,
    KIND_READ  = 3'd3,
    KIND_SKIP  = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic [IDX_W-1:0]            va;
    logic [IDX_W-1:0]            vb;
    logic [IDX_W-1:0]            vc;
    logic signed [POS_IN_W-1:0]  px;
    logic signed [POS_IN_W-1:0]  py;
    logic signed [POS_IN_W-1:0]  pz;
  } cmd_t;

endpackage

FILE: rtl/core/svna_front.sv
// ----------------------------------------------------------------------------
// svna_front
// Unpacks input words, checks vertex indices and classifies each command.
// ----------------------------------------------------------------------------
module svna_front import svna_pkg::*; #(
  parameter int VERTEX_COUNT = DEF_VERTEX_COUNT
) (
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z, two zero bits
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  // action
  input  logic [IN_USER_W-1:0] s_axis_tuser,
  input  logic                 fifo_full,
  output logic                 push,
  output cmd_t                 push_cmd
);

  logic    ra, rb, rc;
  action_t act;

  // Check each index against the vertex count
  always_comb begin
    act = action_t'(s_axis_tuser);
    ra  = CNT_W'(s_axis_tdata[9:0])   < CNT_W'(VERTEX_COUNT);
    rb  = CNT_W'(s_axis_tdata[19:10]) < CNT_W'(VERTEX_COUNT);
    rc  = CNT_W'(s_axis_tdata[29:20]) < CNT_W'(VERTEX_COUNT);
  end

  // Build the command; out-of-range work turns into a plain zero result
  always_comb begin
    push_cmd.va = s_axis_tdata[9:0];
    push_cmd.vb = s_axis_tdata[19:10];
    push_cmd.vc = s_axis_tdata[29:20];
    push_cmd.px = s_axis_tdata[45:30];
    push_cmd.py = s_axis_tdata[61:46];
    push_cmd.pz = s_axis_tdata[77:62];
    unique case (act)
      ACT_CLEAR: push_cmd.kind = KIND_CLEAR;
      ACT_LOAD:  push_cmd.kind = ra ? KIND_LOAD : KIND_SKIP;
      ACT_TRI:   push_cmd.kind = (ra && rb && rc) ? KIND_TRI : KIND_SKIP;
      ACT_READ:  push_cmd.kind = ra ? KIND_READ : KIND_SKIP;
      default:   push_cmd.kind = KIND_SKIP;
    endcase
  end

  assign s_axis_tready = !fifo_full;
  assign push          = s_axis_tvalid && !fifo_full;

endmodule

FILE: rtl/core/svna_fifo.sv
// ----------------------------------------------------------------------------
// svna_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module svna_fifo import svna_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

  cmd_t              slot [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full    = fill == FILL_W'(FIFO_DEPTH);
  assign empty   = fill == '0;
  assign pop_cmd = slot[rd_ptr];

  // Store a pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/svna_norm.sv
// ----------------------------------------------------------------------------
// svna_norm
// Iterative normalizer: scales a signed 3-vector to unit length in Q1.14.
// ----------------------------------------------------------------------------
module svna_norm import svna_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [2:0][VEC_W-1:0]       vec,
  output logic                        done,
  output logic [2:0][NORM_W-1:0]      nrm
);

  localparam int WIN_HI  = 30;
  localparam int SQ_W    = 2 * WIN_HI;
  localparam int ROOT_W  = 63;
  localparam int LEN_W   = 31;
  localparam int FRAC_W  = 14;
  localparam int NUM_W   = LEN_W + FRAC_W;

  typedef enum logic [6:0] {
    N_IDLE  = 7'b0000001,
    N_SHIFT = 7'b0000010,
    N_SQ    = 7'b0000100,
    N_ROOT  = 7'b0001000,
    N_PREP  = 7'b0010000,
    N_DIV   = 7'b0100000,
    N_OUT   = 7'b1000000
  } nstate_t;

  nstate_t                     state;
  logic [2:0]                  sgn;
  logic [2:0][VEC_W-1:0]       mag;
  logic [VEC_W-1:0]            mx;
  logic [3:0]                  cnt;
  logic [SQ_W-1:0]             sq;
  logic [VEC_W-1:0]            acc;
  logic [ROOT_W-1:0]           root_rem;
  logic [ROOT_W-1:0]           root_r;
  logic [ROOT_W-1:0]           root_bit;
  logic [ROOT_W-1:0]           root_try;
  logic [LEN_W-1:0]            len;
  logic [2:0][NUM_W-1:0]       rem;
  logic [NUM_W-1:0]            dvs;
  logic [2:0][QUO_W-1:0]       quo;
  logic [2:0][NORM_W-1:0]      q_ext;
  logic [2:0][NORM_W-1:0]      q_out;

  // Largest magnitude, trial root value and signed outputs
  always_comb begin
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    root_try = root_r + root_bit;
    len      = root_r[LEN_W-1:0];
    for (int i = 0; i < 3; i++) begin
      q_ext[i] = NORM_W'(quo[i]);
      q_out[i] = sgn[i] ? (~q_ext[i] + 1'b1) : q_ext[i];
    end
  end

  // Sequencer: window shift, squares, root, then three division lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              sgn[i] <= vec[i][VEC_W-1];
              mag[i] <= vec[i][VEC_W-1] ? (~vec[i] + 1'b1) : vec[i];
            end
            state <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (mx == '0) begin
            quo   <= '0;
            state <= N_OUT;
          end else if (mx[VEC_W-1:WIN_HI] != '0) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= (mx[VEC_W-1:WIN_HI+4] != '0) ? (mag[i] >> 4) : (mag[i] >> 1);
            end
          end else if (!mx[WIN_HI-1]) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= (mx[WIN_HI-2:WIN_HI-5] == '0) ? (mag[i] << 4) : (mag[i] << 1);
            end
          end else begin
            cnt   <= '0;
            acc   <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt < 4'd3) begin
            sq <= mag[cnt[1:0]][WIN_HI-1:0] * mag[cnt[1:0]][WIN_HI-1:0];
          end
          if (cnt != '0) begin
            acc <= acc + VEC_W'(sq);
          end
          if (cnt == 4'd3) begin
            root_rem <= ROOT_W'(acc) + ROOT_W'(sq);
            root_r   <= '0;
            root_bit <= ROOT_W'(1) << (ROOT_W - 1);
            state    <= N_ROOT;
          end
          cnt <= cnt + 1'b1;
        end
        N_ROOT: begin
          if (root_rem >= root_try) begin
            root_rem <= root_rem - root_try;
            root_r   <= (root_r >> 1) + root_bit;
          end else begin
            root_r <= root_r >> 1;
          end
          root_bit <= root_bit >> 2;
          if (root_bit[0]) begin
            state <= N_PREP;
          end
        end
        N_PREP: begin
          for (int i = 0; i < 3; i++) begin
            rem[i] <= NUM_W'({mag[i][WIN_HI-1:0], FRAC_W'(0)}) + NUM_W'(len[LEN_W-1:1]);
          end
          dvs   <= {len, FRAC_W'(0)};
          quo   <= '0;
          cnt   <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (rem[i] >= dvs) begin
              rem[i] <= rem[i] - dvs;
              quo[i] <= {quo[i][QUO_W-2:0], 1'b1};
            end else begin
              quo[i] <= {quo[i][QUO_W-2:0], 1'b0};
            end
          end
          dvs <= dvs >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == 4'(QUO_W - 1)) begin
            state <= N_OUT;
          end
        end
        N_OUT: begin
          nrm   <= q_out;
          done  <= 1'b1;
          state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/svna_back.sv
// ----------------------------------------------------------------------------
// svna_back
// Executes commands: vertex stores, face normal, sum update and readout.
// ----------------------------------------------------------------------------
module svna_back import svna_pkg::*; #(
  parameter int VERTEX_COUNT  = DEF_VERTEX_COUNT,
  parameter int POSITION_BITS = DEF_POSITION_BITS,
  parameter int SUM_BITS      = DEF_SUM_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fifo_empty,
  input  cmd_t                        cmd,
  output logic                        pop,
  output logic                        norm_start,
  output logic [2:0][VEC_W-1:0]       norm_vec,
  input  logic                        norm_done,
  input  logic [2:0][NORM_W-1:0]      nrm,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [OUT_DATA_W-1:0]       m_axis_tdata,
  // touched
  output logic [OUT_USER_W-1:0]       m_axis_tuser
);

  localparam int AW    = $clog2(VERTEX_COUNT);
  localparam int P     = POSITION_BITS;
  localparam int SB    = SUM_BITS;
  localparam int FIT_W = 33;

  typedef enum logic [11:0] {
    B_SWEEP     = 12'b000000000001,
    B_IDLE      = 12'b000000000010,
    B_POS_A     = 12'b000000000100,
    B_POS_B     = 12'b000000001000,
    B_POS_C     = 12'b000000010000,
    B_MUL       = 12'b000000100000,
    B_NORM_TRI  = 12'b000001000000,
    B_CORNER_RD = 12'b000010000000,
    B_CORNER_WR = 12'b000100000000,
    B_RD_SUM    = 12'b001000000000,
    B_NORM_RD   = 12'b010000000000,
    B_EMIT      = 12'b100000000000
  } bstate_t;

  bstate_t                     state;
  cmd_t                        cur;
  logic [AW-1:0]               sweep_cnt;
  logic                        sweep_emit;
  logic [1:0]                  corner;
  logic [2:0]                  mcnt;
  logic [2:0]                  pk;

  logic [3*P-1:0]              pos_mem [VERTEX_COUNT];
  logic [3*SB-1:0]             sum_mem [VERTEX_COUNT];
  logic                        touch_mem [VERTEX_COUNT];
  logic [3*P-1:0]              pos_rd;
  logic [3*SB-1:0]             sum_rd;
  logic                        touch_rd;

  logic [AW-1:0]               pos_raddr;
  logic [AW-1:0]               sum_raddr;
  logic [AW-1:0]               corner_addr;
  logic                        pos_we;
  logic [3*P-1:0]              pos_wd;
  logic                        touch_we;
  logic [AW-1:0]               touch_wa;
  logic                        touch_wd;
  logic [3*SB-1:0]             sum_wd;

  logic [3*P-1:0]              pa, pb;
  logic [2:0][P:0]             e1_raw, e2_raw;
  logic [2:0][EDGE_W-1:0]      e1, e2;
  logic [2:0][EDGE_W-1:0]      e1_q, e2_q;
  logic signed [EDGE_W-1:0]    mul_a, mul_b;
  logic signed [VEC_W-1:0]     prod;
  logic [2:0][VEC_W-1:0]       nv;
  logic [2:0][NORM_W-1:0]      face;
  logic [2:0][NORM_W-1:0]      res;
  logic                        res_t;

  // Common right shift of one edge until every magnitude is below 2^30
  function automatic logic [2:0][EDGE_W-1:0] fit_edge(input logic [2:0][P:0] e);
    logic [P:0]             neg;
    logic [2:0][FIT_W-1:0]  m;
    logic [FIT_W-1:0]       mxv;
    logic [FIT_W-1:0]       ms;
    logic [EDGE_W-1:0]      r;
    logic [1:0]             sh;
    logic [2:0][EDGE_W-1:0] o;
    for (int i = 0; i < 3; i++) begin
      neg  = ~e[i] + 1'b1;
      m[i] = e[i][P] ? FIT_W'(neg) : FIT_W'(e[i]);
    end
    mxv = m[0];
    if (m[1] > mxv) mxv = m[1];
    if (m[2] > mxv) mxv = m[2];
    sh = mxv[32] ? 2'd3 : (mxv[31] ? 2'd2 : (mxv[30] ? 2'd1 : 2'd0));
    for (int i = 0; i < 3; i++) begin
      ms   = m[i] >> sh;
      r    = {1'b0, ms[EDGE_W-2:0]};
      o[i] = e[i][P] ? (~r + 1'b1) : r;
    end
    return o;
  endfunction

  // Read addresses and write controls
  always_comb begin
    case (corner)
      2'd0:    corner_addr = AW'(cur.va);
      2'd1:    corner_addr = AW'(cur.vb);
      default: corner_addr = AW'(cur.vc);
    endcase
    case (state)
      B_POS_A: pos_raddr = AW'(cur.vb);
      B_POS_B: pos_raddr = AW'(cur.vc);
      default: pos_raddr = AW'(cmd.va);
    endcase
    sum_raddr = (state == B_IDLE) ? AW'(cmd.va) : corner_addr;
    pop       = (state == B_IDLE) && !fifo_empty;
    pos_we    = pop && (cmd.kind == KIND_LOAD);
    pos_wd    = {P'(cmd.pz), P'(cmd.py), P'(cmd.px)};
    touch_we  = (state == B_SWEEP) || (state == B_CORNER_WR);
    touch_wa  = (state == B_SWEEP) ? sweep_cnt : corner_addr;
    touch_wd  = state != B_SWEEP;
    norm_vec  = nv;
  end

  // Edge vectors from the three fetched positions
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_raw[i] = (P+1)'($signed(pb[i*P +: P])) - (P+1)'($signed(pa[i*P +: P]));
      e2_raw[i] = (P+1)'($signed(pos_rd[i*P +: P])) - (P+1)'($signed(pb[i*P +: P]));
    end
    e1 = fit_edge(e1_raw);
    e2 = fit_edge(e2_raw);
  end

  // Cross product operand select, one product per cycle
  always_comb begin
    pk = mcnt - 3'd1;
    case (mcnt)
      3'd0:    begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
      3'd1:    begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
      3'd2:    begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
      3'd3:    begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
      3'd4:    begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
      default: begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
    endcase
  end

  // Saturating update of one vertex sum with the face normal
  always_comb begin
    logic signed [SB-1:0]     old_s;
    logic signed [NORM_W-1:0] n_s;
    logic signed [SB-1:0]     n_ext;
    logic signed [SB:0]       t;
    logic [SB-1:0]            v;
    for (int i = 0; i < 3; i++) begin
      old_s = sum_rd[i*SB +: SB];
      n_s   = face[i];
      n_ext = SB'(n_s);
      t     = (SB+1)'(old_s) + (SB+1)'(n_s);
      if (t[SB] != t[SB-1]) begin
        v = t[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
      end else begin
        v = t[SB-1:0];
      end
      sum_wd[i*SB +: SB] = touch_rd ? v : n_ext;
    end
  end

  // Vertex position store
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[AW'(cmd.va)] <= pos_wd;
    end
    pos_rd <= pos_mem[pos_raddr];
  end

  // Normal sum store
  always_ff @(posedge clk) begin
    if (state == B_CORNER_WR) begin
      sum_mem[corner_addr] <= sum_wd;
    end
    sum_rd <= sum_mem[sum_raddr];
  end

  // Touched mark store
  always_ff @(posedge clk) begin
    if (touch_we) begin
      touch_mem[touch_wa] <= touch_wd;
    end
    touch_rd <= touch_mem[sum_raddr];
  end

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_SWEEP;
      sweep_cnt     <= '0;
      sweep_emit    <= 1'b0;
      norm_start    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      norm_start <= 1'b0;
      if (m_axis_tvalid && m_axis_tready && (state != B_EMIT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        B_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == AW'(VERTEX_COUNT - 1)) begin
            state <= sweep_emit ? B_EMIT : B_IDLE;
          end
        end
        B_IDLE: begin
          if (!fifo_empty) begin
            cur   <= cmd;
            res   <= '0;
            res_t <= 1'b0;
            unique case (cmd.kind)
              KIND_CLEAR: begin
                sweep_cnt  <= '0;
                sweep_emit <= 1'b1;
                state      <= B_SWEEP;
              end
              KIND_TRI:  state <= B_POS_A;
              KIND_READ: state <= B_RD_SUM;
              default:   state <= B_EMIT;
            endcase
          end
        end
        B_POS_A: begin
          pa    <= pos_rd;
          state <= B_POS_B;
        end
        B_POS_B: begin
          pb    <= pos_rd;
          state <= B_POS_C;
        end
        B_POS_C: begin
          pa    <= '0;
          pb    <= '0;
          mcnt  <= '0;
          state <= B_MUL;
        end
        B_MUL: begin
          if (mcnt != 3'd6) begin
            prod <= mul_a * mul_b;
          end
          if (mcnt != 3'd0) begin
            if (!pk[0]) begin
              nv[pk[2:1]] <= prod;
            end else begin
              nv[pk[2:1]] <= nv[pk[2:1]] - prod;
            end
          end
          mcnt <= mcnt + 1'b1;
          if (mcnt == 3'd6) begin
            norm_start <= 1'b1;
            state      <= B_NORM_TRI;
          end
        end
        B_NORM_TRI: begin
          if (norm_done) begin
            face   <= nrm;
            corner <= '0;
            state  <= B_CORNER_RD;
          end
        end
        B_CORNER_RD: state <= B_CORNER_WR;
        B_CORNER_WR: begin
          corner <= corner + 1'b1;
          state  <= (corner == 2'd2) ? B_EMIT : B_CORNER_RD;
        end
        B_RD_SUM: begin
          if (!touch_rd) begin
            state <= B_EMIT;
          end else begin
            for (int i = 0; i < 3; i++) begin
              nv[i] <= VEC_W'($signed(sum_rd[i*SB +: SB]));
            end
            norm_start <= 1'b1;
            state      <= B_NORM_RD;
          end
        end
        B_NORM_RD: begin
          if (norm_done) begin
            res   <= nrm;
            res_t <= 1'b1;
            state <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= res;
            m_axis_tuser  <= res_t;
            m_axis_tvalid <= 1'b1;
            state         <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Edges are taken while the last position is on the read port
  always_ff @(posedge clk) begin
    if (state == B_POS_C) begin
      e1_q <= e1;
      e2_q <= e2;
    end
  end

endmodule

FILE: rtl/core/smooth_vertex_normal_accumulator_unit.sv
// ----------------------------------------------------------------------------
// smooth_vertex_normal_accumulator_unit
// Accumulates unit face normals per vertex and reads back smoothed normals.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per word: tuser is the action (clear, load
//   position, add triangle, read normal), tdata the three vertex indices and
//   a Q7.8 position. m_axis returns exactly one word per command: tdata holds
//   the Q1.14 normal of a read, tuser its touched mark; other commands and
//   out-of-range indices return zeros.
//   A front stage classifies words into a two-entry queue; a back sequencer
//   works them one at a time. A triangle takes three position reads, six
//   shared multiplies, the normalizer and three sum read-modify-writes; a
//   read of a touched vertex takes a sum read and the normalizer. The
//   normalizer does most of that work: a window shift, the squares, 32 root
//   steps and 15 divide steps across three lanes.
//   Clear sweeps the touched marks, one entry per cycle.
//   Reset runs the same sweep before the first command is worked; words are
//   still queued meanwhile. A stalled m_axis holds its word while the back
//   finishes the next command and then waits.
// ----------------------------------------------------------------------------
module smooth_vertex_normal_accumulator_unit import svna_pkg::*; #(
  parameter int VERTEX_COUNT  = DEF_VERTEX_COUNT,
  parameter int POSITION_BITS = DEF_POSITION_BITS,
  parameter int SUM_BITS      = DEF_SUM_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z, two zero bits
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // touched
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  logic                    fifo_full;
  logic                    fifo_empty;
  logic                    push;
  logic                    pop;
  cmd_t                    push_cmd;
  cmd_t                    pop_cmd;
  logic                    norm_start;
  logic                    norm_done;
  logic [2:0][VEC_W-1:0]   norm_vec;
  logic [2:0][NORM_W-1:0]  nrm;

  svna_front #(
    .VERTEX_COUNT(VERTEX_COUNT)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  svna_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (fifo_full),
    .pop     (pop),
    .pop_cmd (pop_cmd),
    .empty   (fifo_empty)
  );

  svna_norm u_norm (
    .clk  (clk),
    .rst  (rst),
    .start(norm_start),
    .vec  (norm_vec),
    .done (norm_done),
    .nrm  (nrm)
  );

  svna_back #(
    .VERTEX_COUNT (VERTEX_COUNT),
    .POSITION_BITS(POSITION_BITS),
    .SUM_BITS     (SUM_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .fifo_empty   (fifo_empty),
    .cmd          (pop_cmd),
    .pop          (pop),
    .norm_start   (norm_start),
    .norm_vec     (norm_vec),
    .norm_done    (norm_done),
    .nrm          (nrm),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Every normal component stays within plus or minus one in Q1.14
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[15:0])  <= 16'sd16384) &&
      ($signed(m_axis_tdata[15:0])  >= -16'sd16384) &&
      ($signed(m_axis_tdata[31:16]) <= 16'sd16384) &&
      ($signed(m_axis_tdata[31:16]) >= -16'sd16384) &&
      ($signed(m_axis_tdata[47:32]) <= 16'sd16384) &&
      ($signed(m_axis_tdata[47:32]) >= -16'sd16384))
    else $error("normal component out of range");

  // A word without the touched mark carries a zero normal
  a_untouched_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("untouched result with nonzero normal");

  // The normalizer start is never raised twice in a row; the back only starts it while it is idle
  a_norm_start: assert property (@(posedge clk) disable iff (rst)
    norm_start |=> !norm_start)
    else $error("normalizer started twice in a row");

endmodule

FILE: tb/svna_checker.sv
// ----------------------------------------------------------------------------
// svna_checker
// Watches both streams of the smooth vertex normal accumulator, predicts each
// output word from the accepted commands and compares it field by field.
// ----------------------------------------------------------------------------
module svna_checker import svna_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [OUT_USER_W-1:0] m_axis_tuser,
  output int                    fail_count,
  output int                    pending_count,
  output int                    read_count,
  output int                    tri_count
);

  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic                     touched;
  } normal_word_t;

  typedef longint vec3_t [3];

  longint       pos_mem [DEF_VERTEX_COUNT][3];
  longint       sum_mem [DEF_VERTEX_COUNT][3];
  bit           touch_mem [DEF_VERTEX_COUNT];
  normal_word_t expected_normals [$];

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale into [2^29, 2^30), then divide by the rounded-down length
  function automatic vec3_t unit_q14(vec3_t c);
    longint unsigned m [3];
    longint unsigned mx, s, len, q;
    vec3_t n;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? -c[i] : c[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      n[0] = 0; n[1] = 0; n[2] = 0;
      return n;
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
    len = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + (len >> 1)) / len;
      n[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
    return n;
  endfunction

  function automatic longint clamp_sum(longint v);
    longint hi;
    hi = (longint'(1) << (DEF_SUM_BITS - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Positions are 16-bit, so edges never need fitting
  task automatic add_face(int a, int b, int c);
    vec3_t e1, e2, cr, n;
    int    idx [3];
    idx[0] = a; idx[1] = b; idx[2] = c;
    for (int i = 0; i < 3; i++) begin
      e1[i] = pos_mem[b][i] - pos_mem[a][i];
      e2[i] = pos_mem[c][i] - pos_mem[b][i];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    n = unit_q14(cr);
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++)
        sum_mem[idx[k]][i] = touch_mem[idx[k]] ? clamp_sum(sum_mem[idx[k]][i] + n[i]) : n[i];
      touch_mem[idx[k]] = 1'b1;
    end
  endtask

  task automatic apply_command(action_t act, logic [IN_DATA_W-1:0] d);
    normal_word_t w;
    vec3_t        s, n;
    int           va, vb, vc;
    w = '0;
    va = d[9:0];
    vb = d[19:10];
    vc = d[29:20];
    case (act)
      ACT_CLEAR: begin
        foreach (touch_mem[i]) touch_mem[i] = 1'b0;
      end
      ACT_LOAD: begin
        pos_mem[va][0] = longint'($signed(d[45:30]));
        pos_mem[va][1] = longint'($signed(d[61:46]));
        pos_mem[va][2] = longint'($signed(d[77:62]));
      end
      ACT_TRI: begin
        add_face(va, vb, vc);
        tri_count++;
      end
      default: begin
        read_count++;
        if (touch_mem[va]) begin
          for (int i = 0; i < 3; i++) s[i] = sum_mem[va][i];
          n = unit_q14(s);
          w.nx = NORM_W'(n[0]);
          w.ny = NORM_W'(n[1]);
          w.nz = NORM_W'(n[2]);
          w.touched = 1'b1;
        end
      end
    endcase
    expected_normals = {expected_normals, w};
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    read_count = 0;
    tri_count = 0;
    foreach (touch_mem[i]) touch_mem[i] = 1'b0;
  end

  // Predict on accepted commands, compare on accepted results
  always @(posedge clk) begin
    normal_word_t got, want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        apply_command(action_t'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got.nx = m_axis_tdata[15:0];
        got.ny = m_axis_tdata[31:16];
        got.nz = m_axis_tdata[47:32];
        got.touched = m_axis_tuser[0];
        if (expected_normals.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected word: %p", got);
        end else begin
          want = expected_normals.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      pending_count = expected_normals.size();
    end
  end

endmodule

FILE: tb/tb_smooth_vertex_normal_accumulator_unit.sv
// ----------------------------------------------------------------------------
// tb_smooth_vertex_normal_accumulator_unit
// Drives load, triangle, read and clear commands under varied stalls; the
// checker predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_smooth_vertex_normal_accumulator_unit;
  import svna_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int POOL        = 24;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  int                    fail_count;
  int                    pending_count;
  int                    read_count;
  int                    tri_count;
  int                    cycle_count;
  int                    send_idle_pct;
  int                    recv_stall_pct;
  bit                    loaded [DEF_VERTEX_COUNT];
  int                    loaded_list [$];

  smooth_vertex_normal_accumulator_unit u_top (.*);

  svna_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog and receiver stalls
  initial begin
    cycle_count = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      cycle_count++;
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout");
        $display("[smooth_vertex_normal_accumulator_unit] ERROR");
        $finish;
      end
    end
  end

  // Idle cycles drop tvalid; the word then stays up until it is taken
  task automatic send_word(action_t act, int va, int vb, int vc, logic [47:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, p, 10'(vc), 10'(vb), 10'(va)};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic load_vertex(int v, logic [47:0] p);
    send_word(ACT_LOAD, v, $urandom_range(1023), $urandom_range(1023), p);
    if (!loaded[v]) loaded_list = {loaded_list, v};
    loaded[v] = 1'b1;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'hFFFF));
      1: return 16'($signed($urandom_range(512)) - 256);
      2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(40)) - 20);
    endcase
  endfunction

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    int base;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_CLEAR;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, degenerate face, zero sum, clear
    load_vertex(0, {16'h0000, 16'h0000, 16'h0000});
    load_vertex(1, {16'h0000, 16'h0000, 16'h7FFF});
    load_vertex(2, {16'h0000, 16'h7FFF, 16'h0000});
    load_vertex(1023, {16'h8000, 16'h8000, 16'h8000});
    load_vertex(5, {16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_word(ACT_READ, 0, 0, 0, '0);
    send_word(ACT_TRI, 0, 1, 2, '0);
    send_word(ACT_TRI, 0, 2, 1, '0);
    send_word(ACT_READ, 0, 0, 0, '0);
    send_word(ACT_READ, 1, 0, 0, '0);
    send_word(ACT_TRI, 0, 0, 1, '0);
    send_word(ACT_TRI, 1023, 5, 2, '0);
    send_word(ACT_READ, 1023, 0, 0, '0);
    send_word(ACT_READ, 5, 0, 0, '0);
    send_word(ACT_CLEAR, 1023, 1023, 1023, 48'hFFFF_FFFF_FFFF);
    send_word(ACT_READ, 1023, 0, 0, '0);
    send_word(ACT_TRI, 1, 2, 5, '0);
    send_word(ACT_TRI, 1, 2, 5, '0);
    send_word(ACT_READ, 1, 0, 0, '0);
    send_word(ACT_CLEAR, 0, 0, 0, '0);
    wait_drain();

    // Random phases with different idle patterns
    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 4) ? 46 : (ph == 3 ? 28 : 0);
      recv_stall_pct = (ph == 2 || ph == 4) ? 46 : (ph == 3 ? 28 : 0);
      base = $urandom_range(1023 - POOL);
      for (int n = 0; n < 305; n++) begin
        int r;
        r = $urandom_range(99);
        if (loaded_list.size() < 3 || r < 20) begin
          load_vertex(base + $urandom_range(POOL - 1),
                      {rand_coord(), rand_coord(), rand_coord()});
        end else if (r < 60) begin
          send_word(ACT_TRI, pick_loaded(), pick_loaded(), pick_loaded(), 48'($urandom()));
        end else if (r < 97) begin
          send_word(ACT_READ, $urandom_range(3) == 0 ? $urandom_range(1023) : pick_loaded(),
                    $urandom_range(1023), $urandom_range(1023), 48'($urandom()));
        end else begin
          send_word(ACT_CLEAR, $urandom_range(1023), $urandom_range(1023),
                    $urandom_range(1023), {$urandom(), 16'($urandom())});
        end
      end
      // Let the queue empty before the next phase
      wait_drain();
    end

    repeat (2000) @(posedge clk);
    $display("covered %0d triangles and %0d normal reads over five idle patterns",
             tri_count, read_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[smooth_vertex_normal_accumulator_unit] OK");
    end else begin
      $display("[smooth_vertex_normal_accumulator_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: smooth_vertex_normal_accumulator_unit.f
rtl/core/svna_pkg.sv
rtl/core/svna_front.sv
rtl/core/svna_fifo.sv
rtl/core/svna_norm.sv
rtl/core/svna_back.sv
rtl/core/smooth_vertex_normal_accumulator_unit.sv
tb/svna_checker.sv
tb/tb_smooth_vertex_normal_accumulator_unit.sv
